// ----- hdl/isim_pkg.sv -----
// Package for the interval set block: table size, widths and operation codes.
// Used by the RAM wrapper users, the controller, the datapath and the top level.
`default_nettype none
package isim_pkg;
  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned INDEX_BITS = 32;
  localparam int unsigned ADDR_W     = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int unsigned TOTAL_W    = 33;
  localparam int unsigned ENTRY_W    = 2 * INDEX_BITS;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic scan_cap;
    logic mv_rd;
    logic mv_wr;
    logic put_new;
    logic put_merge;
    logic sum_rd;
    logic sum_acc;
    logic sum_clr;
    logic clear;
    logic finish;
  } isim_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       found;
    logic       full;
    logic       mv_last;
    logic       sum_last;
  } isim_sts_t;
endpackage
`default_nettype wire

// ----- hdl/isim_ram.sv -----
// Generic single-port RAM with registered read data.
// No package dependencies.
`default_nettype none
module isim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/isim_ctrl.sv -----
// Sequencing controller for the interval set: scan, move, write, recount.
// Depends on isim_pkg.
`default_nettype none
module isim_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire isim_pkg::isim_sts_t sts,
  output isim_pkg::isim_cmd_t      cmd
);
  import isim_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SCANW = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_MVRD  = 4'd5;
  localparam logic [3:0] S_MVWR  = 4'd6;
  localparam logic [3:0] S_PUT   = 4'd7;
  localparam logic [3:0] S_SUMRD = 4'd8;
  localparam logic [3:0] S_SUMAC = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == OP_CLEAR) begin
          cmd.clear = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.op == OP_INSERT || sts.op == OP_QUERY) begin
          if (sts.scan_last) begin
            state_nxt = S_DEC;
          end else begin
            cmd.scan_rd = 1'b1;
            state_nxt = S_SCANW;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DEC;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = S_SCANW;
        end
      end
      S_SCANW: begin
        cmd.scan_cap = 1'b1;
        state_nxt = S_SCAN;
      end
      S_DEC: begin
        if (sts.op != OP_INSERT) begin
          state_nxt = S_DONE;
        end else if (!sts.found && sts.full) begin
          state_nxt = S_DONE;
        end else if (sts.mv_last) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_MVRD;
        end
      end
      S_MVRD: begin
        cmd.mv_rd = 1'b1;
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = sts.mv_last ? S_PUT : S_MVRD;
      end
      S_PUT: begin
        cmd.put_new   = !sts.found;
        cmd.put_merge = sts.found;
        cmd.sum_clr   = 1'b1;
        state_nxt = S_SUMRD;
      end
      S_SUMRD: begin
        if (sts.sum_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.sum_rd = 1'b1;
          state_nxt = S_SUMAC;
        end
      end
      S_SUMAC: begin
        cmd.sum_acc = 1'b1;
        state_nxt = S_SUMRD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/isim_dp.sv -----
// Datapath of the interval set: range table RAM, scan registers, shifter
// pointers, recount adder and result registers. Depends on isim_pkg, isim_ram.
`default_nettype none
module isim_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [1:0]                 in_op,
  input  wire logic [31:0]                in_start_value,
  input  wire logic [31:0]                in_end_value,
  input  wire isim_pkg::isim_cmd_t        cmd,
  output isim_pkg::isim_sts_t             sts,
  output logic                            out_valid,
  output logic                            out_is_contained,
  output logic [6:0]                      out_intervals_held,
  output logic [isim_pkg::TOTAL_W-1:0]    out_indices_covered,
  output logic                            out_table_full
);
  import isim_pkg::*;

  logic [1:0]            op_r;
  logic [INDEX_BITS-1:0] s_r, e_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [CNT_W-1:0]      k_r;
  logic                  found_r, hit_r, pos_ok_r;
  logic [CNT_W-1:0]      lo_r, hi_r, pos_r;
  logic [INDEX_BITS-1:0] ms_r, me_r;
  logic [CNT_W-1:0]      src_r, dst_r;
  logic [TOTAL_W-1:0]    sum_r;
  logic                  full_r;

  logic                  we;
  logic [ADDR_W-1:0]     addr;
  logic [ENTRY_W-1:0]    wdata, rdata;
  logic [INDEX_BITS-1:0] rs, re;
  logic [INDEX_BITS-1:0] a_v, b_v;
  logic [CNT_W-1:0]      gone;
  logic [CNT_W-1:0]      src_dn;

  isim_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RANGES)) u_tab (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rs = rdata[ENTRY_W-1:INDEX_BITS];
  assign re = rdata[INDEX_BITS-1:0];
  assign a_v = in_start_value[INDEX_BITS-1:0];
  assign b_v = in_end_value[INDEX_BITS-1:0];
  assign gone = hi_r - lo_r;
  assign src_dn = src_r - 1'b1;

  // Shift up for a new entry (copy downwards from the top), or down to close
  // the gap left by absorbed entries.
  always_comb begin
    we    = 1'b0;
    addr  = k_r[ADDR_W-1:0];
    wdata = rdata;
    if (cmd.mv_rd) begin
      addr = found_r ? src_r[ADDR_W-1:0] : src_dn[ADDR_W-1:0];
    end else if (cmd.mv_wr) begin
      we   = 1'b1;
      addr = dst_r[ADDR_W-1:0];
    end else if (cmd.put_new) begin
      we    = 1'b1;
      addr  = pos_r[ADDR_W-1:0];
      wdata = {s_r, e_r};
    end else if (cmd.put_merge) begin
      we    = 1'b1;
      addr  = lo_r[ADDR_W-1:0];
      wdata = {ms_r, me_r};
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.scan_last = (k_r == cnt_r);
    sts.found     = found_r;
    sts.full      = (cnt_r == CNT_W'(MAX_RANGES));
    sts.sum_last  = (k_r == cnt_r);
    if (!found_r) begin
      sts.mv_last = (src_r == pos_r) || !pos_ok_r && 1'b0 || (src_r == pos_r);
    end else begin
      sts.mv_last = (gone == '0) || (src_r == cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      total_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.clear) begin
        cnt_r   <= '0;
        total_r <= '0;
      end
      if (cmd.put_new) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.put_merge) begin
        cnt_r <= cnt_r - gone;
      end
      if (cmd.finish && op_r == OP_INSERT && !(!found_r && full_r)) begin
        total_r <= sum_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      s_r      <= (a_v <= b_v) ? a_v : b_v;
      e_r      <= (a_v <= b_v) ? b_v : a_v;
      k_r      <= '0;
      found_r  <= 1'b0;
      hit_r    <= 1'b0;
      pos_ok_r <= 1'b0;
      pos_r    <= cnt_r;
      lo_r     <= '0;
      hi_r     <= '0;
      full_r   <= sts.full;
    end
    if (cmd.scan_cap) begin
      k_r <= k_r + 1'b1;
      if ({1'b0, rs} <= {1'b0, e_r} + 1'b1 && {1'b0, re} + 1'b1 >= {1'b0, s_r}) begin
        if (!found_r) begin
          lo_r    <= k_r;
          ms_r    <= (rs < s_r) ? rs : s_r;
        end
        found_r <= 1'b1;
        hi_r    <= k_r;
        me_r    <= (re > e_r) ? re : e_r;
      end
      if (!pos_ok_r && rs > e_r) begin
        pos_ok_r <= 1'b1;
        pos_r    <= k_r;
      end
      if (rs <= s_r && re >= e_r) begin
        hit_r <= 1'b1;
      end
    end
    // Set up the move pointers once the scan has finished.
    if (cmd.scan_rd == 1'b0 && cmd.scan_cap == 1'b0 && sts.scan_last && !cmd.mv_rd
        && !cmd.mv_wr && !cmd.put_new && !cmd.put_merge && !cmd.sum_rd && !cmd.sum_acc
        && !cmd.finish && !cmd.load && !cmd.sum_clr) begin
      if (!found_r) begin
        src_r <= cnt_r;
        dst_r <= cnt_r;
      end else begin
        src_r <= hi_r + 1'b1;
        dst_r <= lo_r + 1'b1;
      end
    end
    if (cmd.mv_rd) begin
      if (!found_r) begin
        src_r <= src_r - 1'b1;
      end else begin
        src_r <= src_r + 1'b1;
      end
    end
    if (cmd.mv_wr) begin
      if (!found_r) begin
        dst_r <= dst_r - 1'b1;
      end else begin
        dst_r <= dst_r + 1'b1;
      end
    end
    if (cmd.put_new || cmd.put_merge) begin
      k_r <= '0;
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end
    if (cmd.sum_acc) begin
      k_r <= k_r + 1'b1;
      if ({1'b0, sum_r} + {2'b0, (re - rs)} + 1'b1 > {1'b0, {TOTAL_W{1'b1}}}) begin
        sum_r <= {TOTAL_W{1'b1}};
      end else begin
        sum_r <= sum_r + TOTAL_W'(re - rs) + 1'b1;
      end
    end
    if (cmd.finish) begin
      out_is_contained    <= (op_r == OP_QUERY) && hit_r;
      out_table_full      <= (op_r == OP_INSERT) && !found_r && full_r;
      out_intervals_held  <= 7'(cnt_r);
      out_indices_covered <= (op_r == OP_INSERT && !(!found_r && full_r)) ? sum_r :
                             (op_r == OP_CLEAR) ? '0 : total_r;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/interval_set_insert_merge.sv -----
// Top level of the interval set block: controller plus datapath.
// Depends on isim_pkg, isim_ctrl, isim_dp.
//
// A set of up to 64 sorted, disjoint ranges. Each item is started with start
// while busy is low; exactly one result follows, shown for one cycle with
// out_valid, and the receiver cannot stall it. An insert or a query scans every
// stored entry through the single RAM port; an insert that is stored then makes
// a move pass over the shifted entries and a recount pass over every entry. A
// clear does not scan the table.
`default_nettype none
module interval_set_insert_merge (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_start_value,
  input  wire logic [31:0] in_end_value,
  output logic             out_valid,
  output logic             out_is_contained,
  output logic [6:0]       out_intervals_held,
  output logic [32:0]      out_indices_covered,
  output logic             out_table_full
);
  import isim_pkg::*;

  isim_cmd_t cmd;
  isim_sts_t sts;

  isim_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  isim_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_op(in_op), .in_start_value(in_start_value),
    .in_end_value(in_end_value), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_is_contained(out_is_contained), .out_intervals_held(out_intervals_held),
    .out_indices_covered(out_indices_covered), .out_table_full(out_table_full)
  );
endmodule
`default_nettype wire

// ----- verif/interval_set_insert_merge_tb.sv -----
// Testbench for interval_set_insert_merge: directed and random inserts, queries and clears.
// Depends on isim_pkg and the block's RTL. A local model of the range table predicts each result.
`default_nettype none
module interval_set_insert_merge_tb;
  import isim_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [32:0] TOTAL_SAT = {33{1'b1}};

  typedef struct packed {
    logic        contained;
    logic [6:0]  held;
    logic [32:0] covered;
    logic        full;
  } range_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_op = OP_INSERT;
  logic [31:0] in_start_value = '0;
  logic [31:0] in_end_value = '0;
  wire         busy;
  wire         out_valid;
  wire         out_is_contained;
  wire  [6:0]  out_intervals_held;
  wire  [32:0] out_indices_covered;
  wire         out_table_full;

  interval_set_insert_merge DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_start_value(in_start_value), .in_end_value(in_end_value),
    .out_valid(out_valid), .out_is_contained(out_is_contained),
    .out_intervals_held(out_intervals_held), .out_indices_covered(out_indices_covered),
    .out_table_full(out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the range table.
  logic [31:0] lo_tab [MAX_RANGES];
  logic [31:0] hi_tab [MAX_RANGES];
  int unsigned n_ranges = 0;
  logic [32:0] cover_sum = '0;

  range_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned full_drops = 0;
  int unsigned query_hits = 0;
  bit quiet_sender = 1'b0;

  function automatic void recount_cover();
    logic [33:0] acc;
    acc = '0;
    for (int k = 0; k < n_ranges; k++) begin
      acc = acc + ({2'b0, hi_tab[k]} - {2'b0, lo_tab[k]} + 34'd1);
      if (acc > {1'b0, TOTAL_SAT}) acc = {1'b0, TOTAL_SAT};
    end
    cover_sum = acc[32:0];
  endfunction

  function automatic bit insert_range(logic [31:0] s, logic [31:0] e);
    int lo_i, hi_i, pos, gone;
    bit found;
    found = 1'b0;
    lo_i = 0;
    hi_i = 0;
    for (int k = 0; k < n_ranges; k++) begin
      if ({1'b0, lo_tab[k]} <= {1'b0, e} + 33'd1 && {1'b0, hi_tab[k]} + 33'd1 >= {1'b0, s}) begin
        if (!found) lo_i = k;
        found = 1'b1;
        hi_i = k;
      end
    end
    if (!found) begin
      if (n_ranges >= MAX_RANGES) return 1'b1;
      pos = n_ranges;
      for (int k = 0; k < n_ranges; k++) begin
        if (lo_tab[k] > e) begin
          pos = k;
          break;
        end
      end
      for (int k = n_ranges; k > pos; k--) begin
        lo_tab[k] = lo_tab[k-1];
        hi_tab[k] = hi_tab[k-1];
      end
      lo_tab[pos] = s;
      hi_tab[pos] = e;
      n_ranges++;
      return 1'b0;
    end
    if (s < lo_tab[lo_i]) lo_tab[lo_i] = s;
    hi_tab[lo_i] = (hi_tab[hi_i] > e) ? hi_tab[hi_i] : e;
    gone = hi_i - lo_i;
    for (int k = hi_i + 1; k < n_ranges; k++) begin
      lo_tab[k-gone] = lo_tab[k];
      hi_tab[k-gone] = hi_tab[k];
    end
    n_ranges -= gone;
    return 1'b0;
  endfunction

  function automatic range_result_t predict_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    range_result_t r;
    logic [31:0] s, e;
    s = (a <= b) ? a : b;
    e = (a <= b) ? b : a;
    r = '0;
    case (op)
      OP_INSERT: begin
        r.full = insert_range(s, e);
        recount_cover();
      end
      OP_QUERY: begin
        for (int k = 0; k < n_ranges; k++)
          if (lo_tab[k] <= s && hi_tab[k] >= e) r.contained = 1'b1;
      end
      OP_CLEAR: begin
        n_ranges = 0;
        cover_sum = '0;
      end
      default: ;
    endcase
    r.held = n_ranges[6:0];
    r.covered = cover_sum;
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    if (!quiet_sender) begin
      while ($urandom_range(99) < 11) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_start_value <= a;
    in_end_value <= b;
    // Busy only moves at a rising edge, so its value at the falling edge
    // still holds at the next rising edge.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(predict_item(op, a, b));
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      range_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_is_contained !== want.contained) begin
          $error("is_contained: expected %0d, got %0d", want.contained, out_is_contained);
          error_count++;
        end
        if (out_intervals_held !== want.held) begin
          $error("intervals_held: expected %0d, got %0d", want.held, out_intervals_held);
          error_count++;
        end
        if (out_indices_covered !== want.covered) begin
          $error("indices_covered: expected %0d, got %0d", want.covered, out_indices_covered);
          error_count++;
        end
        if (out_table_full !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, out_table_full);
          error_count++;
        end
        if (want.full) full_drops++;
        if (want.contained) query_hits++;
      end
    end
  end

  function automatic logic [31:0] rand_index(int unsigned span);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(span);
      2: return $urandom_range(3);
      default: return $urandom_range(span);
    endcase
  endfunction

  task automatic test_extremes();
    send_item(OP_QUERY, 32'd0, 32'd0);
    send_item(OP_INSERT, 32'd0, 32'd0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'd10, 32'd5);
    send_item(OP_INSERT, 32'd12, 32'd20);
    send_item(OP_INSERT, 32'd11, 32'd11);
    send_item(OP_QUERY, 32'd20, 32'd5);
    send_item(OP_INSERT, 32'd100, 32'd200);
    send_item(OP_INSERT, 32'd50, 32'd60);
    send_item(OP_INSERT, 32'd1, 32'd300);
    send_item(OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'd3, 32'd3);
  endtask

  // Fills the table with isolated points, then overflows it.
  task automatic test_full_table();
    send_item(OP_CLEAR, 32'd0, 32'd0);
    for (int k = 0; k < MAX_RANGES; k++) send_item(OP_INSERT, 32'(4 * k), 32'(4 * k));
    send_item(OP_INSERT, 32'd1000, 32'd1000);
    send_item(OP_INSERT, 32'd1, 32'd2);
    send_item(OP_INSERT, 32'd5, 32'd500);
    send_item(OP_QUERY, 32'd6, 32'd200);
    send_item(OP_CLEAR, 32'd0, 32'd0);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned span;
    int unsigned r;
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      quiet_sender = (i >= count / 3 && i < count / 2);
      span = ($urandom_range(3) == 0) ? 32'hFFFF : 600;
      r = $urandom_range(99);
      a = rand_index(span);
      if (r < 55) send_item(OP_INSERT, a, ($urandom_range(4) == 0) ? $urandom() : a + $urandom_range(6));
      else if (r < 90) send_item(OP_QUERY, a, a + $urandom_range(20));
      else if (r < 93) send_item(OP_CLEAR, $urandom(), $urandom());
      else if (r < 95) send_item(OP_UNUSED, $urandom(), $urandom());
      else send_item(OP_INSERT, $urandom(), $urandom());
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_table();
    test_random(1100);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (450) @(posedge clk);
    $display("Ran %0d results: %0d dropped inserts on a full table, %0d query hits.",
             results_seen, full_drops, query_hits);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
